/* sv/alidf_pkg.sv */
// ----------------------------------------------------------------------------
// alidf_pkg
// Types and constants shared by the array list blocks: item layouts,
// operation and status codes, cell control and controller states.
// ----------------------------------------------------------------------------
package alidf_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FUNC_W = 2;
    localparam int POS_W  = 4;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;

    // hit bits examined per cycle during a find scan
    localparam int SCAN_LANES  = 8;
    localparam int SCAN_LANE_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_FIND   = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_BADPOS   = 2'd2,
        STS_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        t_func                   func;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  found_index;
        logic [CNT_W-1:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic ins_en;
        logic del_en;
        logic find_en;
    } t_cell_ctl;

endpackage

/* sv/alidf_cell.sv */
// ----------------------------------------------------------------------------
// alidf_cell
// One list slot: holds an entry, takes from its left or right neighbor on
// insert or delete, and flags a match on find.
// ----------------------------------------------------------------------------
module alidf_cell
    import alidf_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CMP_W      = 9
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [CMP_W-1:0]      i_pos,
    input  logic [CMP_W-1:0]      i_occ,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_entry,
    output logic                  o_hit
);

    localparam logic [CMP_W-1:0] K = CMP_W'(IDX);

    logic [DATA_WIDTH-1:0] r_entry, n_entry;
    logic                  r_hit, n_hit;

    always_comb begin
        n_entry = r_entry;
        n_hit   = r_hit;
        if (i_ctl.ins_en) begin
            // move up above the insert point, take the new word at it
            if (K > i_pos) begin
                n_entry = i_left;
            end else if (K == i_pos) begin
                n_entry = i_word;
            end
        end
        if (i_ctl.del_en && (K >= i_pos)) begin
            n_entry = i_right;
        end
        if (i_ctl.find_en) begin
            n_hit = (K < i_occ) && (r_entry == i_word);
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_hit   <= n_hit;
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

/* sv/alidf_ctrl.sv */
// ----------------------------------------------------------------------------
// alidf_ctrl
// Operation control: checks each item against the occupancy, drives the
// cell row, scans the hit bits for a find and holds the result register.
// ----------------------------------------------------------------------------
module alidf_ctrl
    import alidf_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    output t_cell_ctl             o_ctl,
    output logic [$clog2(CAPACITY + 1)+POS_W-1:0] o_pos,
    output logic [$clog2(CAPACITY + 1)+POS_W-1:0] o_occ,
    output logic [DATA_WIDTH-1:0] o_word,
    input  logic [CAPACITY-1:0]   i_hits
);

    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = OCC_W + POS_W;
    localparam int NCHUNK = (CAPACITY + SCAN_LANES - 1) / SCAN_LANES;
    localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int HIT_W  = NCHUNK * SCAN_LANES;
    localparam logic [CHK_W-1:0] LAST_CHUNK = CHK_W'(NCHUNK - 1);
    localparam logic [OCC_W-1:0] OCC_FULL   = OCC_W'(CAPACITY);

    t_state                r_state, n_state;
    logic [OCC_W-1:0]      r_occ, n_occ;
    logic [CHK_W-1:0]      r_chunk, n_chunk;
    logic                  r_out_valid;
    t_out_item             r_out_item, n_out_item;

    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_load;
    logic                         w_ins_ok;
    logic                         w_del_ok;
    logic [CMP_W-1:0]             w_pos;
    logic [CMP_W-1:0]             w_occ;
    logic signed [DATA_WIDTH+VAL_W-1:0] w_val_ext;
    logic [HIT_W-1:0]             w_hits;
    logic [SCAN_LANES-1:0]        w_chunk_hits;
    logic                         w_chunk_any;
    logic [SCAN_LANE_W-1:0]       w_lane;
    logic                         w_last;
    logic [CHK_W+SCAN_LANE_W-1:0] w_fidx;
    logic [OCC_W+CNT_W-1:0]       w_cnt_ext;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_pos     = CMP_W'(i_in_item.position);
    assign w_occ     = CMP_W'(r_occ);
    assign w_val_ext = (DATA_WIDTH + VAL_W)'(i_in_item.value);
    assign w_ins_ok  = (r_occ < OCC_FULL) && (w_pos <= w_occ);
    assign w_del_ok  = (w_pos < w_occ);

    assign o_pos  = w_pos;
    assign o_occ  = w_occ;
    assign o_word = w_val_ext[DATA_WIDTH-1:0];

    // find scan: one group of hit bits per cycle, lowest index wins
    assign w_hits       = HIT_W'(i_hits);
    assign w_chunk_hits = w_hits[r_chunk * SCAN_LANES +: SCAN_LANES];
    assign w_chunk_any  = |w_chunk_hits;
    assign w_last       = (r_chunk == LAST_CHUNK);
    assign w_fidx       = {r_chunk, w_lane};

    always_comb begin
        w_lane = '0;
        for (int i = SCAN_LANES - 1; i >= 0; i--) begin
            if (w_chunk_hits[i]) begin
                w_lane = SCAN_LANE_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_item.func == FN_FIND)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((w_chunk_any || w_last) && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: cell control, occupancy, scan position and result
    always_comb begin
        o_ctl       = '0;
        n_occ       = r_occ;
        n_chunk     = r_chunk;
        w_load      = 1'b0;
        n_out_item  = r_out_item;
        n_out_item.status      = STS_OK;
        n_out_item.found_index = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_chunk = '0;
                    unique case (i_in_item.func)
                        FN_INSERT: begin
                            if (r_occ >= OCC_FULL) begin
                                n_out_item.status = STS_FULL;
                            end else if (!w_ins_ok) begin
                                n_out_item.status = STS_BADPOS;
                            end else begin
                                o_ctl.ins_en = 1'b1;
                                n_occ        = r_occ + 1'b1;
                            end
                            w_load = 1'b1;
                        end
                        FN_DELETE: begin
                            if (!w_del_ok) begin
                                n_out_item.status = STS_BADPOS;
                            end else begin
                                o_ctl.del_en = 1'b1;
                                n_occ        = r_occ - 1'b1;
                            end
                            w_load = 1'b1;
                        end
                        FN_FIND: begin
                            o_ctl.find_en = 1'b1;
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_chunk_any) begin
                    n_out_item.found_index = w_fidx[IDX_W-1:0];
                    w_load = w_out_free;
                end else if (w_last) begin
                    n_out_item.status = STS_NOTFOUND;
                    w_load = w_out_free;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            default: ;
        endcase
        w_cnt_ext = (OCC_W + CNT_W)'(n_occ);
        n_out_item.entry_count = w_cnt_ext[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_chunk <= n_chunk;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* sv/array_list_insert_delete_find_top.sv */
// ----------------------------------------------------------------------------
// array_list_insert_delete_find_top
// Ordered list of up to CAPACITY signed words with insert, delete and find.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one operation
// item: func, position and value. Output channel (o_out_valid / i_out_ready
// / o_out_item) returns one result item per operation: status, found_index
// and entry_count after the operation.
// Entries sit in a row of cells; each cell takes its left neighbor on an
// insert, its right neighbor on a delete, and compares against the key on
// a find.
// Insert, delete and unused codes load the result register at acceptance, so
// it is valid in the cycle after. A find registers the compare bits in the
// accept cycle, then scans them eight per cycle until a hit or the last group.
// Throughput: one insert or delete per cycle while results are taken; one
// find at a time, set by the hit scan. The input accepts a new item while a
// result waits, as long as the result register frees in the same cycle.
// Reset empties the list; entry contents are left as they are. When the
// receiver stalls, the result is held and further input waits.
// ----------------------------------------------------------------------------
module array_list_insert_delete_find_top
    import alidf_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = OCC_W + POS_W;

    t_cell_ctl             w_ctl;
    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_occ;
    logic [DATA_WIDTH-1:0] w_word;
    logic [DATA_WIDTH-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0]   w_hits;

    alidf_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_ctl       (w_ctl),
        .o_pos       (w_pos),
        .o_occ       (w_occ),
        .o_word      (w_word),
        .i_hits      (w_hits)
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        // chain ends: first cell never shifts up, last cell keeps its entry
        if (k == 0) begin : g_first
            assign w_left = w_word;
        end else begin : g_mid_l
            assign w_left = w_entry[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[k];
        end else begin : g_mid_r
            assign w_right = w_entry[k+1];
        end

        alidf_cell #(
            .IDX        (k),
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_occ   (w_occ),
            .i_word  (w_word),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[k]),
            .o_hit   (w_hits[k])
        );
    end

endmodule
